>>> rtl/stt_pkg.sv
// shared types and constants of the transposition table
package stt_pkg;

    typedef enum logic [1:0] {
        ACT_SAVE     = 2'd0,
        ACT_SAVE_NEW = 2'd1,
        ACT_PROBE    = 2'd2,
        ACT_MOVE     = 2'd3
    } action_t;

    localparam logic [1:0] BOUND_EXACT = 2'd0;
    localparam logic [1:0] BOUND_UPPER = 2'd1;
    localparam logic [1:0] BOUND_LOWER = 2'd2;

    localparam logic signed [15:0] SCORE_UNKNOWN  = -16'sd32767;
    localparam logic [7:0]         NULL_DEPTH_MIN = 8'd3;
    localparam logic [31:0]        HITS_MAX       = 32'hFFFF_FFFF;

    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 80;

    typedef struct packed {
        logic [63:0]        key;
        logic signed [15:0] score;
        logic [7:0]         depth;
        logic [1:0]         bound;
        logic [15:0]        move;
    } entry_t;

    typedef struct packed {
        action_t            action;
        logic [63:0]        key;
        logic [7:0]         depth;
        logic signed [15:0] score;
        logic [1:0]         bound;
        logic [15:0]        move;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
    } item_t;

    typedef struct packed {
        logic match;
        logic usable;
        logic avoid;
        logic write;
    } verdict_t;

endpackage

>>> rtl/stt_judge.sv
// decides match, usable score, null-move hint and replacement for one entry
module stt_judge
    import stt_pkg::*;
(
    input  item_t    item,
    input  entry_t   stored,
    output verdict_t verdict
);

    logic match;
    logic deep_enough;
    logic usable;

    assign match       = (stored.key == item.key);
    assign deep_enough = (stored.depth >= item.depth);

    always_comb
    begin
        usable = 1'b0;
        if (item.action == ACT_PROBE && match && deep_enough)
        begin
            case (stored.bound)
                BOUND_EXACT: usable = (stored.score > item.alpha) && (stored.score < item.beta);
                BOUND_UPPER: usable = (stored.score <= item.alpha);
                BOUND_LOWER: usable = (stored.score >= item.beta);
                default:     usable = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        verdict.match  = match;
        verdict.usable = usable;
        verdict.avoid  = usable && (stored.bound == BOUND_UPPER) && (stored.score < item.beta)
                         && (item.depth >= NULL_DEPTH_MIN);
        case (item.action)
            // keep an exact entry of the same key against a weaker bound
            ACT_SAVE:     verdict.write = !match
                                          || !(stored.bound == BOUND_EXACT
                                               && item.bound != BOUND_EXACT);
            ACT_SAVE_NEW: verdict.write = !match;
            default:      verdict.write = 1'b0;
        endcase
    end

endmodule

>>> rtl/search_transposition_table_core.sv
// direct-mapped search transposition table with probe, save and move query
//
//  channel  | dir | tdata                                         | tuser
//  ---------+-----+-----------------------------------------------+--------
//  s_axis   | in  | key, depth, score, bound, move, alpha, beta   | action
//  m_axis   | out | matched, usable, avoid, score, depth, bound,  | -
//           |     | move, hit count                               |
//
// each item passes through two steps: accept and entry read, then compare and write back
// the registered entry read sets those steps; the result lands in an output
// register so the next item is taken while a result still waits
// after reset a clearing pass writes every entry with s_tready low; a stalled
// result holds the item in its lookup state
module search_transposition_table_core
    import stt_pkg::*;
#(
    parameter int INDEX_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // key[63:0] depth[71:64] score[87:72] bound[89:88] move[105:90]
    // window_low[121:106] window_high[137:122], zero fill above
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // action[1:0]
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // key_matched[0] score_usable[1] avoid_null[2] stored_score[18:3]
    // stored_depth[26:19] stored_bound[28:27] stored_move[44:29] hit_count[76:45]
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int DEPTH = 2 ** INDEX_BITS;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK
    } state_t;

    state_t                  state_reg;
    logic [INDEX_BITS-1:0]   clr_cnt_reg;
    item_t                   item_reg;
    logic                    m_tvalid_reg;
    logic [OUT_DATA_W-1:0]   m_tdata_reg;
    logic [31:0]             hits_reg;
    logic [31:0]             hits_next;

    entry_t                  mem [DEPTH];
    entry_t                  rd_data_reg;
    entry_t                  wr_data;
    logic [INDEX_BITS-1:0]   wr_addr;
    logic                    wr_en;
    logic                    rd_en;

    item_t                   in_item;
    verdict_t                verdict;
    logic                    commit;
    logic [OUT_DATA_W-1:0]   result;

    assign in_item.action = action_t'(s_tuser);
    assign in_item.key    = s_tdata[63:0];
    assign in_item.depth  = s_tdata[71:64];
    assign in_item.score  = s_tdata[87:72];
    assign in_item.bound  = s_tdata[89:88];
    assign in_item.move   = s_tdata[105:90];
    assign in_item.alpha  = s_tdata[121:106];
    assign in_item.beta   = s_tdata[137:122];

    assign s_tready = (state_reg == S_IDLE);
    assign rd_en    = s_tvalid && s_tready;
    assign commit   = (state_reg == S_LOOK) && (!m_tvalid_reg || m_tready);

    stt_judge u_judge (
        .item    (item_reg),
        .stored  (rd_data_reg),
        .verdict (verdict)
    );

    always_comb
    begin
        hits_next = hits_reg;
        if (item_reg.action == ACT_PROBE && verdict.match && hits_reg != HITS_MAX)
        begin
            hits_next = hits_reg + 32'd1;
        end
    end

    always_comb
    begin
        result        = '0;
        result[0]     = verdict.match;
        result[1]     = verdict.usable;
        result[2]     = verdict.avoid;
        if (verdict.match)
        begin
            result[18:3]  = rd_data_reg.score;
            result[26:19] = rd_data_reg.depth;
            result[28:27] = rd_data_reg.bound;
            result[44:29] = rd_data_reg.move;
        end
        result[76:45] = hits_next;
    end

    // write port: clearing pass, else the write-back of the item in hand
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            wr_en         = 1'b1;
            wr_addr       = clr_cnt_reg;
            wr_data.key   = '0;
            wr_data.score = SCORE_UNKNOWN;
            wr_data.depth = '0;
            wr_data.bound = BOUND_EXACT;
            wr_data.move  = '0;
        end
        else
        begin
            wr_en         = commit && verdict.write;
            wr_addr       = item_reg.key[INDEX_BITS-1:0];
            wr_data.key   = item_reg.key;
            wr_data.score = item_reg.score;
            wr_data.depth = item_reg.depth;
            wr_data.bound = item_reg.bound;
            wr_data.move  = item_reg.move;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[in_item.key[INDEX_BITS-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            hits_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (&clr_cnt_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (rd_en)
                    begin
                        item_reg  <= in_item;
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    if (commit)
                    begin
                        hits_reg    <= hits_next;
                        m_tdata_reg <= result;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (commit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // the hit counter only ever climbs
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> hits_reg >= $past(hits_reg))
        else $error("hit counter went down");

    // a new result only comes out of a lookup
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_LOOK))
        else $error("result without lookup");

    // a lookup is always preceded by an accepted read
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_LOOK) |-> $past(rd_en))
        else $error("lookup without entry read");

    // no item write-back or entry read while the clearing pass runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !commit && !rd_en)
        else $error("item handled during clearing");

endmodule

>>> bench/tb_search_transposition_table_core.sv
// self-checking stream testbench for the direct-mapped transposition table core
module tb_search_transposition_table_core;
    import stt_pkg::*;

    localparam int TT_BITS     = 12;
    localparam int TT_SLOTS    = 1 << TT_BITS;
    localparam int POOL_N      = 24;
    localparam int HOLD_LEN    = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 20;

    typedef struct packed {
        logic               matched;
        logic               usable;
        logic               avoid;
        logic [15:0]        score;
        logic [7:0]         depth;
        logic [1:0]         bound;
        logic [15:0]        move;
        logic [31:0]        hits;
    } tt_reply_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    // mirror of the table contents
    logic [63:0]        slot_key   [TT_SLOTS];
    logic signed [15:0] slot_score [TT_SLOTS];
    logic [7:0]         slot_depth [TT_SLOTS];
    logic [1:0]         slot_bound [TT_SLOTS];
    logic [15:0]        slot_move  [TT_SLOTS];
    logic [31:0]        hit_total;

    tt_reply_t   awaited_replies[$];
    tt_reply_t   head_reply;
    logic [63:0] key_pool[POOL_N];
    int          error_count;
    int          cycle_count;
    logic        tx_jitter;
    logic        rx_jitter;
    int          hold_tickets;
    int          hold_seen;
    int          stall_left;

    search_transposition_table_core #(
        .INDEX_BITS (TT_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver: random stalls, plus a long hold-off whenever one is asked for
    always @(posedge clk)
    begin
        if (hold_seen != hold_tickets)
        begin
            hold_seen  <= hold_seen + 1;
            stall_left <= HOLD_LEN - 1;
            m_tready   <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (rx_jitter && $urandom_range(0, 3) == 0)
        begin
            stall_left <= pick_gap() - 1;
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic report_field(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_replies.size() == 0)
            begin
                $display("%0t: result with none expected, expected none, got %0h",
                         $time, m_tdata);
                error_count++;
            end
            else
            begin
                head_reply = awaited_replies.pop_front();
                report_field("key_matched",  32'(head_reply.matched), 32'(m_tdata[0]));
                report_field("score_usable", 32'(head_reply.usable),  32'(m_tdata[1]));
                report_field("avoid_null",   32'(head_reply.avoid),   32'(m_tdata[2]));
                report_field("stored_score", 32'(head_reply.score),   32'(m_tdata[18:3]));
                report_field("stored_depth", 32'(head_reply.depth),   32'(m_tdata[26:19]));
                report_field("stored_bound", 32'(head_reply.bound),   32'(m_tdata[28:27]));
                report_field("stored_move",  32'(head_reply.move),    32'(m_tdata[44:29]));
                report_field("hit_count",    head_reply.hits,         m_tdata[76:45]);
            end
        end
    end

    // works out the reply of one item and updates the mirrored entry
    task automatic resolve_op(input item_t op, output tt_reply_t rep);
        logic [TT_BITS-1:0] ix;
        logic               hit;
        logic               usable;
        logic               wr;
        ix     = op.key[TT_BITS-1:0];
        hit    = slot_key[ix] == op.key;
        usable = 1'b0;
        wr     = 1'b0;
        case (op.action)
            ACT_SAVE:
                wr = !hit || !(slot_bound[ix] == BOUND_EXACT && op.bound != BOUND_EXACT);
            ACT_SAVE_NEW:
                wr = !hit;
            ACT_PROBE:
                if (hit)
                begin
                    if (hit_total != HITS_MAX)
                        hit_total++;
                    if (slot_depth[ix] >= op.depth)
                        usable = (slot_bound[ix] == BOUND_EXACT && slot_score[ix] > op.alpha
                                  && slot_score[ix] < op.beta)
                              || (slot_bound[ix] == BOUND_UPPER && slot_score[ix] <= op.alpha)
                              || (slot_bound[ix] == BOUND_LOWER && slot_score[ix] >= op.beta);
                end
            default: ;
        endcase
        rep.matched = hit;
        rep.usable  = usable;
        rep.avoid   = usable && slot_bound[ix] == BOUND_UPPER && slot_score[ix] < op.beta
                      && op.depth >= NULL_DEPTH_MIN;
        rep.score   = hit ? slot_score[ix] : '0;
        rep.depth   = hit ? slot_depth[ix] : '0;
        rep.bound   = hit ? slot_bound[ix] : '0;
        rep.move    = hit ? slot_move[ix]  : '0;
        rep.hits    = hit_total;
        if (wr)
        begin
            slot_key[ix]   = op.key;
            slot_score[ix] = op.score;
            slot_depth[ix] = op.depth;
            slot_bound[ix] = op.bound;
            slot_move[ix]  = op.move;
        end
    endtask

    task automatic send_op(input item_t op);
        tt_reply_t rep;
        int        gap;
        s_tdata  <= {6'b0, op.beta, op.alpha, op.move, op.bound, op.score, op.depth, op.key};
        s_tuser  <= op.action;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        resolve_op(op, rep);
        awaited_replies.push_back(rep);
        gap = (tx_jitter && $urandom_range(0, 1)) ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic item_t mk_op(action_t act, logic [63:0] key, logic [7:0] depth,
                                    logic signed [15:0] score, logic [1:0] bound,
                                    logic [15:0] move, logic signed [15:0] alpha,
                                    logic signed [15:0] beta);
        item_t op;
        op.action = act;
        op.key    = key;
        op.depth  = depth;
        op.score  = score;
        op.bound  = bound;
        op.move   = move;
        op.alpha  = alpha;
        op.beta   = beta;
        return op;
    endfunction

    function automatic item_t random_op();
        item_t              op;
        int                 r;
        int                 centre;
        logic [TT_BITS-1:0] ix;
        r = $urandom_range(0, 99);
        op.action = r < 35 ? ACT_SAVE : r < 50 ? ACT_SAVE_NEW : r < 85 ? ACT_PROBE : ACT_MOVE;
        r = $urandom_range(0, 99);
        if (r < 80)
            op.key = key_pool[$urandom_range(0, POOL_N - 1)];
        else if (r < 90)
            op.key = {$urandom, $urandom};
        else if (r < 95)
            op.key = 64'h0;
        else
            op.key = {$urandom, $urandom} & ~64'(TT_SLOTS - 1);
        ix = op.key[TT_BITS-1:0];
        op.depth = 8'($urandom_range(0, 99) < 80 ? $urandom_range(0, 12)
                                                 : $urandom_range(0, 255));
        if (op.action == ACT_PROBE && $urandom_range(0, 1))
            op.depth = 8'($urandom_range(0, slot_depth[ix]));
        op.score = 16'($urandom_range(0, 99) < 70 ? int'($urandom_range(0, 400)) - 200
                                                  : int'($urandom));
        r = $urandom_range(0, 9);
        op.bound = r == 9 ? 2'd3 : 2'(r % 3);
        op.move  = 16'($urandom);
        if ($urandom_range(0, 1))
        begin
            // window around the stored score so cut-offs actually happen
            centre   = int'(slot_score[ix]);
            op.alpha = 16'(centre + int'($urandom_range(0, 60)) - 30);
            op.beta  = 16'(centre + int'($urandom_range(0, 60)) - 30);
        end
        else
        begin
            op.alpha = 16'($urandom);
            op.beta  = 16'($urandom);
        end
        return op;
    endfunction

    // every slot holds key zero after the clearing pass
    task automatic test_cleared_table();
        send_op(mk_op(ACT_PROBE, 64'h0, 8'd0, 0, BOUND_EXACT, 16'h0, -32768, 32767));
        send_op(mk_op(ACT_PROBE, 64'hFFFF_FFFF_FFFF_F000, 8'd0, 0, BOUND_EXACT, 16'h0,
                      -32768, 32767));
        send_op(mk_op(ACT_MOVE, 64'h0, 8'd0, 0, BOUND_EXACT, 16'h0, 0, 0));
        send_op(mk_op(ACT_SAVE_NEW, 64'h0, 8'd9, 77, BOUND_LOWER, 16'h1111, 0, 0));
        drain();
    endtask

    task automatic test_directed_cases();
        logic [63:0] k1;
        logic [63:0] k2;
        logic [63:0] k3;
        k1 = 64'hFFFF_FFFF_FFFF_FFFF;
        k2 = 64'h0123_4567_89AB_CDEF;
        k3 = k2 ^ 64'h8000_0000_0000_0000;
        send_op(mk_op(ACT_SAVE, k1, 8'd255, 32767, BOUND_EXACT, 16'hFFFF, 0, 0));
        send_op(mk_op(ACT_PROBE, k1, 8'd255, 0, BOUND_EXACT, 16'h0, -32768, 32767));
        // exact entry survives a non-exact save of the same key
        send_op(mk_op(ACT_SAVE, k1, 8'd0, -32768, BOUND_UPPER, 16'h0, 0, 0));
        send_op(mk_op(ACT_MOVE, k1, 8'd0, 0, BOUND_EXACT, 16'h0, 0, 0));
        send_op(mk_op(ACT_SAVE, k1, 8'd7, 100, BOUND_EXACT, 16'h1234, 0, 0));
        send_op(mk_op(ACT_SAVE, k2, 8'd9, -50, BOUND_UPPER, 16'hABCD, 0, 0));
        send_op(mk_op(ACT_PROBE, k2, 8'd3, 0, BOUND_EXACT, 16'h0, -50, 100));
        send_op(mk_op(ACT_PROBE, k2, 8'd10, 0, BOUND_EXACT, 16'h0, -50, 100));
        send_op(mk_op(ACT_SAVE, k2, 8'd4, 200, BOUND_LOWER, 16'h5555, 0, 0));
        send_op(mk_op(ACT_PROBE, k2, 8'd4, 0, BOUND_EXACT, 16'h0, -100, 200));
        send_op(mk_op(ACT_SAVE, k2, 8'd20, 5, 2'd3, 16'h0, 0, 0));
        send_op(mk_op(ACT_PROBE, k2, 8'd0, 0, BOUND_EXACT, 16'h0, 32767, -32768));
        send_op(mk_op(ACT_SAVE_NEW, k2, 8'd1, 1, BOUND_EXACT, 16'h7777, 0, 0));
        // same slot, different key
        send_op(mk_op(ACT_SAVE_NEW, k3, 8'd1, -32768, BOUND_EXACT, 16'h8001, 0, 0));
        send_op(mk_op(ACT_PROBE, k2, 8'd0, 0, BOUND_EXACT, 16'h0, -32768, 32767));
        send_op(mk_op(ACT_MOVE, k2, 8'd0, 0, BOUND_EXACT, 16'h0, 0, 0));
        send_op(mk_op(ACT_PROBE, k3, 8'd1, 0, BOUND_EXACT, 16'h0, -32768, 0));
        send_op(mk_op(ACT_SAVE, k3, 8'd2, 0, BOUND_EXACT, 16'h2AAA, 0, 0));
        send_op(mk_op(ACT_PROBE, k3, 8'd2, 0, BOUND_EXACT, 16'h0, -1, 1));
        send_op(mk_op(ACT_SAVE, k3, 8'd2, 9, BOUND_UPPER, 16'h0, 0, 0));
        send_op(mk_op(ACT_PROBE, k3, 8'd0, 0, BOUND_EXACT, 16'h0, -1, 1));
        drain();
    endtask

    task automatic test_back_to_back();
        tx_jitter = 1'b0;
        rx_jitter = 1'b0;
        repeat (100) send_op(random_op());
        drain();
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        tx_jitter = 1'b0;
        rx_jitter = 1'b0;
        hold_tickets++;
        repeat (40) send_op(random_op());
        drain();
    endtask

    task automatic test_random_traffic();
        tx_jitter = 1'b1;
        rx_jitter = 1'b1;
        repeat (560) send_op(random_op());
        drain();
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = ACT_SAVE;
        m_tready     = 1'b0;
        error_count  = 0;
        cycle_count  = 0;
        tx_jitter    = 1'b1;
        rx_jitter    = 1'b1;
        hold_tickets = 0;
        hold_seen    = 0;
        stall_left   = 0;
        hit_total    = '0;
        for (int i = 0; i < TT_SLOTS; i++)
        begin
            slot_key[i]   = '0;
            slot_score[i] = SCORE_UNKNOWN;
            slot_depth[i] = '0;
            slot_bound[i] = BOUND_EXACT;
            slot_move[i]  = '0;
        end
        // keys in threes share a slot, so collisions are frequent
        for (int i = 0; i < POOL_N; i++)
        begin
            key_pool[i] = {$urandom, $urandom};
            if (i % 3 != 0)
                key_pool[i][TT_BITS-1:0] = key_pool[i - 1][TT_BITS-1:0];
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_cleared_table();
        test_directed_cases();
        test_back_to_back();
        test_backpressure();
        test_random_traffic();

        repeat (SETTLE) @(posedge clk);
        if (error_count == 0 && awaited_replies.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> files.f
rtl/stt_pkg.sv
rtl/stt_judge.sv
rtl/search_transposition_table_core.sv
bench/tb_search_transposition_table_core.sv
